### design/psg_pkg.sv
`default_nettype none

package psg_pkg;

    // Default widths of the prime value and the run position.
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int INDEX_WIDTH_DEF = 20;

    // Table length register: width and value after reset.
    localparam int          TL_W        = 21;
    localparam logic [20:0] TL_RESET    = 21'd1024;

    // The first prime, where every run and every divisor sweep begins.
    localparam int FIRST_PRIME = 2;

endpackage

`default_nettype wire

### design/prime_sequence_generator_core.sv
// Operation: each candidate is tested against trial divisors in turn in the
//   bit-serial divider until a prime is found; while the overflow hold is set,
//   a word is emitted with no search.
// Throughput: one word at a time; the next request is taken as soon as the
//   result sits in the output register, even if it is not yet taken.
// Reset: synchronous, active low; the run restarts at 2 with table length 1024.
`default_nettype none

module prime_sequence_generator_core #(
    parameter int VALUE_WIDTH = psg_pkg::VALUE_WIDTH_DEF,
    parameter int INDEX_WIDTH = psg_pkg::INDEX_WIDTH_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire [psg_pkg::TL_W-1:0] i_cfg_wdata,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire                     i_restart,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output logic [VALUE_WIDTH-1:0]  o_prime_value,
    output logic [INDEX_WIDTH-1:0]  o_prime_position,
    output logic                    o_last_of_run,
    output logic                    o_overflow
);
    import psg_pkg::*;

    localparam int CMP_W = (INDEX_WIDTH + 1 > TL_W) ? INDEX_WIDTH + 1 : TL_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TEST = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [VALUE_WIDTH-1:0] FIRST = VALUE_WIDTH'(FIRST_PRIME);

    logic [1:0]             r_state, n_state;
    logic [TL_W-1:0]        r_table, n_table;
    logic [VALUE_WIDTH-1:0] r_cand, n_cand;
    logic [VALUE_WIDTH-1:0] r_div, n_div;
    logic [INDEX_WIDTH-1:0] r_count, n_count;
    logic                   r_hold, n_hold;
    logic                   r_out_valid, n_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_value, n_out_value;
    logic [INDEX_WIDTH-1:0] r_out_pos, n_out_pos;
    logic                   r_out_last, n_out_last;
    logic                   r_out_ovf, n_out_ovf;

    logic                   w_div_done;
    logic [VALUE_WIDTH-1:0] w_quot;
    logic [VALUE_WIDTH-1:0] w_rem;
    logic                   w_last;
    logic                   w_at_max;
    logic                   w_out_free;

    // Divides the candidate by the current trial divisor.
    psg_serial_div #(
        .W (VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_TEST),
        .i_dividend (r_cand),
        .i_divisor  (r_div),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_last     = (CMP_W'(r_count) + CMP_W'(1)) == CMP_W'(r_table);
    assign w_at_max   = &r_cand;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Sequencer: restart handling, divisor sweep, candidate search, emit.
    always_comb begin
        n_state     = r_state;
        n_table     = i_cfg_we ? i_cfg_wdata : r_table;
        n_cand      = r_cand;
        n_div       = r_div;
        n_count     = r_count;
        n_hold      = r_hold;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_value = r_out_value;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_div = FIRST;
                    if (i_restart) begin
                        n_cand  = FIRST;
                        n_count = '0;
                        n_hold  = 1'b0;
                    end
                    n_state = (i_restart || !r_hold) ? S_TEST : S_EMIT;
                end
            end
            S_TEST: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (r_div > w_quot) begin
                        // No divisor up to the square root: the candidate is prime.
                        n_state = S_EMIT;
                    end else if (w_rem == '0) begin
                        if (w_at_max) begin
                            n_hold  = 1'b1;
                            n_state = S_EMIT;
                        end else begin
                            n_cand  = r_cand + VALUE_WIDTH'(1);
                            n_div   = FIRST;
                            n_state = S_TEST;
                        end
                    end else begin
                        n_div   = r_div + VALUE_WIDTH'(1);
                        n_state = S_TEST;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = r_count;
                    n_div       = FIRST;
                    n_state     = S_IDLE;
                    if (r_hold) begin
                        n_out_value = '0;
                        n_out_last  = 1'b0;
                        n_out_ovf   = 1'b1;
                    end else begin
                        n_out_value = r_cand;
                        n_out_last  = w_last;
                        n_out_ovf   = 1'b0;
                        if (w_last) begin
                            n_cand  = FIRST;
                            n_count = '0;
                        end else begin
                            n_count = r_count + INDEX_WIDTH'(1);
                            if (w_at_max) begin
                                n_hold = 1'b1;
                            end else begin
                                n_cand = r_cand + VALUE_WIDTH'(1);
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_table     <= TL_RESET;
            r_cand      <= FIRST;
            r_div       <= FIRST;
            r_count     <= '0;
            r_hold      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_table     <= n_table;
            r_cand      <= n_cand;
            r_div       <= n_div;
            r_count     <= n_count;
            r_hold      <= n_hold;
            r_out_valid <= n_out_valid;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_pos   <= n_out_pos;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_prime_value    = r_out_value;
    assign o_prime_position = r_out_pos;
    assign o_last_of_run    = r_out_last;
    assign o_overflow       = r_out_ovf;

endmodule

`default_nettype wire

### design/psg_serial_div.sv
`default_nettype none

// Restoring divider that takes one quotient bit per cycle. The dividend
// shifts out MSB first and the quotient shifts in at the LSB, MSB first.
module psg_serial_div #(
    parameter int W = psg_pkg::VALUE_WIDTH_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire [W-1:0]   i_dividend,
    input  wire [W-1:0]   i_divisor,
    output logic          o_done,
    output logic [W-1:0]  o_quot,
    output logic [W-1:0]  o_rem
);
    localparam int CNT_W = $clog2(W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_dvd, n_dvd;
    logic [W-1:0]     r_dsr, n_dsr;
    logic [W-1:0]     r_quo, n_quo;
    logic [W-1:0]     r_rem, n_rem;
    logic [W:0]       w_trial;
    logic [W:0]       w_diff;
    logic             w_ge;

    // The partial remainder stays below twice the divisor, so the sign of
    // the difference tells whether the divisor fits.
    assign w_trial = {r_rem, r_dvd[W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_ge    = ~w_diff[W];

    // One division step per cycle while busy.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(W - 1);
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
            n_quo  = '0;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
            n_quo = {r_quo[W-2:0], w_ge};
            n_dvd = {r_dvd[W-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Data shift registers.
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

### design/psg_checker.sv
`default_nettype none

module psg_checker #(
    parameter int VALUE_WIDTH = psg_pkg::VALUE_WIDTH_DEF,
    parameter int INDEX_WIDTH = psg_pkg::INDEX_WIDTH_DEF
) (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   o_out_valid,
    input wire                   i_out_ready,
    input wire [VALUE_WIDTH-1:0] o_prime_value,
    input wire [INDEX_WIDTH-1:0] o_prime_position,
    input wire                   o_last_of_run,
    input wire                   o_overflow
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    // An overflow word carries no prime and never closes a run.
    a_ovf_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |-> (o_prime_value == '0 && !o_last_of_run))
        else $error("overflow word carries a value or a last flag");

    // A prime is 2 or odd.
    a_prime_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_overflow) |->
        (o_prime_value[0] || o_prime_value == VALUE_WIDTH'(2)))
        else $error("emitted value is not a possible prime");

    // A stalled word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_prime_value) && $stable(o_prime_position)))
        else $error("stalled output word changed");

endmodule

bind prime_sequence_generator_core psg_checker #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH)
) u_psg_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_prime_value    (o_prime_value),
    .o_prime_position (o_prime_position),
    .o_last_of_run    (o_last_of_run),
    .o_overflow       (o_overflow)
);

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import psg_pkg::*;

    // The block runs at its default widths.
    localparam int          VAL_W     = VALUE_WIDTH_DEF;
    localparam int          IDX_W     = INDEX_WIDTH_DEF;
    localparam int unsigned VALUE_TOP = {VAL_W{1'b1}};
    localparam int          LIMIT     = 3_000_000;
    localparam int          SETTLE    = 4 * (VAL_W + 2);

    typedef enum int {
        RX_STREAM,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_mode;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] position;
        logic             last;
        logic             ovf;
    } t_prime_word;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [TL_W-1:0]   i_cfg_wdata = '0;
    logic              i_in_valid  = 1'b0;
    logic              i_restart   = 1'b0;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [VAL_W-1:0]  o_prime_value;
    logic [IDX_W-1:0]  o_prime_position;
    logic              o_last_of_run;
    logic              o_overflow;

    // Shadow state of the generator.
    int unsigned       next_candidate = FIRST_PRIME;
    logic [IDX_W-1:0]  run_count      = '0;
    logic              search_hold    = 1'b0;
    logic [TL_W-1:0]   table_len      = TL_RESET;

    t_prime_word       owed_primes[$];
    t_prime_word       head_word;
    int                error_count = 0;
    int                cycle_count = 0;
    int                burst_left  = 0;
    t_rx_mode          rx_mode     = RX_STREAM;
    int                rx_left     = 0;

    prime_sequence_generator_core #(
        .VALUE_WIDTH (VAL_W),
        .INDEX_WIDTH (IDX_W)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_restart        (i_restart),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_prime_value    (o_prime_value),
        .o_prime_position (o_prime_position),
        .o_last_of_run    (o_last_of_run),
        .o_overflow       (o_overflow)
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The receiver switches between streaming, random stalls and sparse accepts.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
            rx_left <= $urandom_range(50, 400);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_STREAM: begin
                i_out_ready <= 1'b1;
            end
            RX_RANDOM: begin
                i_out_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                i_out_ready <= (cycle_count[1:0] == 2'b00);
            end
        endcase
    end

    function automatic logic is_prime_val(input int unsigned n);
        int unsigned d;
        if (n < FIRST_PRIME)
            return 1'b0;
        for (d = FIRST_PRIME; d * d <= n; d++) begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advances the shadow state by one request and returns the word it yields.
    function automatic t_prime_word next_prime_word(input logic restart_bit);
        t_prime_word w;
        int unsigned c;
        if (restart_bit) begin
            next_candidate = FIRST_PRIME;
            run_count      = '0;
            search_hold    = 1'b0;
        end
        c = next_candidate;
        while (!search_hold && !is_prime_val(c)) begin
            if (c >= VALUE_TOP)
                search_hold = 1'b1;
            else
                c++;
        end
        w.position = run_count;
        if (search_hold) begin
            w.value = '0;
            w.last  = 1'b0;
            w.ovf   = 1'b1;
            return w;
        end
        w.value = c[VAL_W-1:0];
        w.ovf   = 1'b0;
        w.last  = ((int'(run_count) + 1) == int'(table_len));
        if (w.last) begin
            next_candidate = FIRST_PRIME;
            run_count      = '0;
        end else begin
            run_count = run_count + 1'b1;
            if (c >= VALUE_TOP)
                search_hold = 1'b1;
            else
                next_candidate = c + 1;
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR at cycle %0d: %s: got %0d, expected %0d",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // Result checker: each word accepted is compared with the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_primes.size() == 0) begin
                report_mismatch("word with no request, value", 64'(o_prime_value), 64'(0));
            end else begin
                head_word = owed_primes.pop_front();
                if (o_prime_value !== head_word.value)
                    report_mismatch("prime value", 64'(o_prime_value),
                                    64'(head_word.value));
                if (o_prime_position !== head_word.position)
                    report_mismatch("prime position", 64'(o_prime_position),
                                    64'(head_word.position));
                if (o_last_of_run !== head_word.last)
                    report_mismatch("last of run", 64'(o_last_of_run),
                                    64'(head_word.last));
                if (o_overflow !== head_word.ovf)
                    report_mismatch("overflow", 64'(o_overflow), 64'(head_word.ovf));
            end
        end
    end

    // Sends one request word; the sender works in bursts with random gaps.
    task automatic send_request(input logic restart_bit);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_restart  <= restart_bit;
        do @(posedge i_clk); while (!o_in_ready);
        owed_primes.push_back(next_prime_word(restart_bit));
    endtask

    // Holds the sender off until every owed word has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (owed_primes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_table_length(input logic [TL_W-1:0] len);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        table_len = len;
    endtask

    // Default table length after reset, then a restart in the middle of a run.
    task automatic test_reset_state();
        repeat (6) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
    endtask

    // A table length of one makes every word the last of its run.
    task automatic test_single_prime_runs();
        write_table_length(TL_W'(1));
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
    endtask

    // Short runs wrap back to 2; a new length applies mid-run without a restart.
    task automatic test_short_runs();
        write_table_length(TL_W'(3));
        send_request(1'b1);
        repeat (4) send_request(1'b0);
        write_table_length(TL_W'(2));
        repeat (3) send_request(1'b0);
    endtask

    // With no run end the search keeps climbing, then a restart brings it back.
    task automatic test_long_run();
        write_table_length('0);
        send_request(1'b1);
        repeat (20) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
    endtask

    // Random requests under a series of table lengths, extremes included.
    task automatic test_random_traffic();
        logic [TL_W-1:0] len;
        int phase;
        int n;
        for (phase = 0; phase < 9; phase++) begin
            case (phase)
                0:       len = TL_W'(1 << IDX_W);
                1:       len = TL_W'((1 << IDX_W) + 1);
                2:       len = 21'd1048576;
                3:       len = {TL_W{1'b1}};
                4:       len = '0;
                default: len = TL_W'($urandom_range(1, 20));
            endcase
            write_table_length(len);
            for (n = 0; n < 6; n++)
                send_request($urandom_range(0, 11) == 0);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_single_prime_runs();
        test_short_runs();
        test_long_run();
        test_random_traffic();
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (owed_primes.size() != 0)
            report_mismatch("words still owed", 64'(owed_primes.size()), 64'(0));
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
